// ===== rtl/core/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // Input word: one HSV pixel
    typedef struct packed {
        logic [15:0] hue_sixtyfourths;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } hsv_pixel_t;

    // Output word: one RGB pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_pixel_t;

    // 60-degree hue sectors, in order around the color wheel
    typedef enum logic [2:0] {
        SEC_RED_YELLOW    = 3'd0,
        SEC_YELLOW_GREEN  = 3'd1,
        SEC_GREEN_CYAN    = 3'd2,
        SEC_CYAN_BLUE     = 3'd3,
        SEC_BLUE_MAGENTA  = 3'd4,
        SEC_MAGENTA_RED   = 3'd5
    } sector_t;

    // Hue is in 1/64 degree units
    localparam logic [15:0] HUE_FULL_TURN  = 16'd23040;
    localparam logic [15:0] HUE_TWO_TURNS  = 16'd46080;
    localparam logic [11:0] HUE_SECTOR     = 12'd3840;

    // Divisor of the chroma-plus-offset level: 255 * 3840
    localparam logic [19:0] XM_DIVISOR     = 20'd979200;
    // floor(2^40 / 979200); estimate is low by at most one
    localparam logic [20:0] XM_RECIP       = 21'd1122867;
    localparam int          XM_RECIP_SHIFT = 40;

    // Pipeline depth, input register through output register
    localparam int          NUM_STAGES     = 7;

endpackage

// ===== rtl/core/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Seven-stage pipelined HSV to RGB pixel converter with valid/ready channels.
// ----------------------------------------------------------------------------
// The converter takes one HSV word per clock and returns one RGB word per
// clock while m_ready stays high; an accepted word passes the stage registers
// in order, from the reduced hue to the output word, before it reaches m_valid.
// Hue is reduced modulo 360 degrees, split into six sectors, and the
// intermediate channel level is divided by 255*3840 with a reciprocal multiply
// followed by a one-step correction; every channel is truncated exactly. Each
// stage holds its own valid bit and stalls only when it is full and the stage
// ahead of it cannot advance, so bubbles close up while m_ready is low and no
// word is lost or repeated.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  hsv_pixel_t s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output rgb_pixel_t m_data
);

    // Stage valid bits and load enables
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] stg_en;

    // Stage 1: reduced hue
    logic [14:0] hr1_reg;
    logic [7:0]  s1_reg;
    logic [7:0]  v1_reg;
    logic [14:0] hr1_next;

    // Stage 2: sector, distance from full chroma, offset product
    sector_t     sec2_reg;
    logic [11:0] d2_reg;
    logic [7:0]  s2_reg;
    logic [7:0]  v2_reg;
    logic [15:0] p2_reg;
    sector_t     sec2_next;
    logic [11:0] d2_next;
    logic [15:0] p2_next;

    // Stage 3: saturation times distance, offset level
    sector_t     sec3_reg;
    logic [19:0] sd3_reg;
    logic [7:0]  v3_reg;
    logic [7:0]  mm3_reg;
    logic [19:0] sd3_next;
    logic [7:0]  mm3_next;

    // Stage 4: numerator of the mixed level
    sector_t     sec4_reg;
    logic [27:0] n4_reg;
    logic [7:0]  v4_reg;
    logic [7:0]  mm4_reg;
    logic [27:0] n4_next;

    // Stage 5: quotient estimate
    sector_t     sec5_reg;
    logic [27:0] n5_reg;
    logic [7:0]  q5_reg;
    logic [7:0]  v5_reg;
    logic [7:0]  mm5_reg;
    logic [7:0]  q5_next;

    // Stage 6: corrected mixed level
    sector_t     sec6_reg;
    logic [7:0]  xm6_reg;
    logic [7:0]  v6_reg;
    logic [7:0]  mm6_reg;
    logic [27:0] rem6;
    logic [7:0]  xm6_next;

    // Stage 7: output word
    rgb_pixel_t  m_data_reg;
    rgb_pixel_t  m_data_next;

    // ------------------------------------------------------------------
    // Handshake: a stage loads when empty or when the stage ahead moves
    // ------------------------------------------------------------------
    always_comb begin
        stg_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stg_en[i] = !vld_reg[i] || stg_en[i+1];
        end
        vld_next[0] = stg_en[0] ? s_valid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            vld_next[i] = stg_en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = stg_en[0];
    assign m_valid = vld_reg[NUM_STAGES-1];
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Stage 1: wrap hue into one turn
    // ------------------------------------------------------------------
    always_comb begin
        if (s_data.hue_sixtyfourths >= HUE_TWO_TURNS) begin
            hr1_next = 15'(s_data.hue_sixtyfourths - HUE_TWO_TURNS);
        end else if (s_data.hue_sixtyfourths >= HUE_FULL_TURN) begin
            hr1_next = 15'(s_data.hue_sixtyfourths - HUE_FULL_TURN);
        end else begin
            hr1_next = s_data.hue_sixtyfourths[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[0]) begin
            hr1_reg <= hr1_next;
            s1_reg  <= s_data.saturation;
            v1_reg  <= s_data.brightness;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: find sector and distance of x from chroma
    // ------------------------------------------------------------------
    always_comb begin
        logic [14:0] base;
        logic [11:0] ofs;
        if (hr1_reg < 15'(HUE_SECTOR)) begin
            sec2_next = SEC_RED_YELLOW;
            base      = 15'd0;
        end else if (hr1_reg < 15'(2 * HUE_SECTOR)) begin
            sec2_next = SEC_YELLOW_GREEN;
            base      = 15'(HUE_SECTOR);
        end else if (hr1_reg < 15'(3 * HUE_SECTOR)) begin
            sec2_next = SEC_GREEN_CYAN;
            base      = 15'(2 * HUE_SECTOR);
        end else if (hr1_reg < 15'(4 * HUE_SECTOR)) begin
            sec2_next = SEC_CYAN_BLUE;
            base      = 15'(3 * HUE_SECTOR);
        end else if (hr1_reg < 15'(5 * HUE_SECTOR)) begin
            sec2_next = SEC_BLUE_MAGENTA;
            base      = 15'(4 * HUE_SECTOR);
        end else begin
            sec2_next = SEC_MAGENTA_RED;
            base      = 15'(5 * HUE_SECTOR);
        end
        ofs = 12'(hr1_reg - base);
        // rising sectors: x grows with offset, so the gap to chroma shrinks
        d2_next = sec2_next[0] ? ofs : 12'(HUE_SECTOR - ofs);
        p2_next = v1_reg * (8'd255 - s1_reg);
    end

    always_ff @(posedge aclk) begin
        if (stg_en[1]) begin
            sec2_reg <= sec2_next;
            d2_reg   <= d2_next;
            s2_reg   <= s1_reg;
            v2_reg   <= v1_reg;
            p2_reg   <= p2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale the gap by saturation, divide offset by 255
    // ------------------------------------------------------------------
    always_comb begin
        logic [16:0] mm_sum;
        sd3_next = 20'(s2_reg * d2_reg);
        mm_sum   = {1'b0, p2_reg} + {9'd0, p2_reg[15:8]} + 17'd1;
        mm3_next = mm_sum[15:8];
    end

    always_ff @(posedge aclk) begin
        if (stg_en[2]) begin
            sec3_reg <= sec2_reg;
            sd3_reg  <= sd3_next;
            v3_reg   <= v2_reg;
            mm3_reg  <= mm3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: numerator v * (255*3840 - s*d)
    // ------------------------------------------------------------------
    assign n4_next = 28'(v3_reg * (XM_DIVISOR - sd3_reg));

    always_ff @(posedge aclk) begin
        if (stg_en[3]) begin
            sec4_reg <= sec3_reg;
            n4_reg   <= n4_next;
            v4_reg   <= v3_reg;
            mm4_reg  <= mm3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: quotient estimate by reciprocal multiply
    // ------------------------------------------------------------------
    always_comb begin
        logic [48:0] prod;
        prod    = n4_reg * XM_RECIP;
        q5_next = prod[XM_RECIP_SHIFT +: 8];
    end

    always_ff @(posedge aclk) begin
        if (stg_en[4]) begin
            sec5_reg <= sec4_reg;
            n5_reg   <= n4_reg;
            q5_reg   <= q5_next;
            v5_reg   <= v4_reg;
            mm5_reg  <= mm4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: correct the estimate by one where the remainder overflows
    // ------------------------------------------------------------------
    always_comb begin
        rem6     = n5_reg - 28'(q5_reg * XM_DIVISOR);
        xm6_next = (rem6 >= 28'(XM_DIVISOR)) ? q5_reg + 8'd1 : q5_reg;
    end

    always_ff @(posedge aclk) begin
        if (stg_en[5]) begin
            sec6_reg <= sec5_reg;
            xm6_reg  <= xm6_next;
            v6_reg   <= v5_reg;
            mm6_reg  <= mm5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: place chroma, mixed and offset levels by sector
    // ------------------------------------------------------------------
    always_comb begin
        case (sec6_reg)
            SEC_RED_YELLOW: begin
                m_data_next = '{red: v6_reg, green: xm6_reg, blue: mm6_reg};
            end
            SEC_YELLOW_GREEN: begin
                m_data_next = '{red: xm6_reg, green: v6_reg, blue: mm6_reg};
            end
            SEC_GREEN_CYAN: begin
                m_data_next = '{red: mm6_reg, green: v6_reg, blue: xm6_reg};
            end
            SEC_CYAN_BLUE: begin
                m_data_next = '{red: mm6_reg, green: xm6_reg, blue: v6_reg};
            end
            SEC_BLUE_MAGENTA: begin
                m_data_next = '{red: xm6_reg, green: mm6_reg, blue: v6_reg};
            end
            default: begin
                m_data_next = '{red: v6_reg, green: mm6_reg, blue: xm6_reg};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stg_en[6]) begin
            m_data_reg <= m_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // An accepted word must occupy the first stage next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted word missing from first stage");

    // A full numerator stage that cannot advance keeps its word
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] && !stg_en[3] |=> vld_reg[3] && $stable(n4_reg))
        else $error("stalled stage lost its word");

    // The reciprocal estimate is never off by more than one
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[4] |-> rem6 < 28'(2 * XM_DIVISOR))
        else $error("quotient estimate out of range");

    // Mixed level lies between offset and brightness
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[5] |-> (mm6_reg <= xm6_reg) && (xm6_reg <= v6_reg))
        else $error("mixed level outside offset..brightness");

endmodule

// ===== sim/hsv_to_rgb_converter_test.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_test
// Self-checking testbench for the pipelined HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
// HSV words are driven on the s_ channel and every accepted word is run
// through an exact integer predictor. The expected RGB words wait in a queue
// and each word leaving the m_ channel is compared field by field against
// the oldest one. Directed words cover the corners of the color wheel, the
// wrap of the hue and the gray and black cases; random words follow under
// three idling profiles, with one pause that lets the pipeline drain.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test
    import hsv2rgb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned TWO_SECTORS = 2 * HUE_SECTOR;
    localparam int              CYCLE_LIMIT = 200000;
    localparam int              RANDOM_WORDS = 1600;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    hsv_pixel_t s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    rgb_pixel_t m_data;

    rgb_pixel_t expected_rgb[$];
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         words_sent = 0;
    int         words_checked = 0;
    int         error_count = 0;
    int         cycle_count = 0;

    hsv_to_rgb_converter uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock: 2 ns period
    always #1 aclk = ~aclk;

    // Exact integer color wheel: place chroma and x by sector, then add offset
    function automatic rgb_pixel_t predict_rgb(hsv_pixel_t px);
        longint unsigned hr, sat, val, ramp, pos, full_lvl, ramp_lvl, base_lvl;
        sector_t         sec;
        rgb_pixel_t      rgb;
        hr       = px.hue_sixtyfourths % HUE_FULL_TURN;
        sat      = px.saturation;
        val      = px.brightness;
        sec      = sector_t'(hr / HUE_SECTOR);
        pos      = hr % TWO_SECTORS;
        ramp     = (pos < HUE_SECTOR) ? pos : TWO_SECTORS - pos;
        full_lvl = val;
        ramp_lvl = (val * (sat * ramp + (255 - sat) * HUE_SECTOR)) / XM_DIVISOR;
        base_lvl = (val * (255 - sat)) / 255;
        case (sec)
            SEC_RED_YELLOW: begin
                rgb = {full_lvl[7:0], ramp_lvl[7:0], base_lvl[7:0]};
            end
            SEC_YELLOW_GREEN: begin
                rgb = {ramp_lvl[7:0], full_lvl[7:0], base_lvl[7:0]};
            end
            SEC_GREEN_CYAN: begin
                rgb = {base_lvl[7:0], full_lvl[7:0], ramp_lvl[7:0]};
            end
            SEC_CYAN_BLUE: begin
                rgb = {base_lvl[7:0], ramp_lvl[7:0], full_lvl[7:0]};
            end
            SEC_BLUE_MAGENTA: begin
                rgb = {ramp_lvl[7:0], base_lvl[7:0], full_lvl[7:0]};
            end
            default: begin
                rgb = {full_lvl[7:0], base_lvl[7:0], ramp_lvl[7:0]};
            end
        endcase
        return rgb;
    endfunction

    task automatic report_mismatch(string field, logic [7:0] want, logic [7:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Check each word leaving the block, then record each word entering it
    always @(posedge aclk) begin : check_rgb
        rgb_pixel_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                words_checked++;
                if (expected_rgb.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected word, expected none, actual %h",
                             $time, m_data);
                end else begin
                    want = expected_rgb.pop_front();
                    if (m_data.red !== want.red) begin
                        report_mismatch("red", want.red, m_data.red);
                    end
                    if (m_data.green !== want.green) begin
                        report_mismatch("green", want.green, m_data.green);
                    end
                    if (m_data.blue !== want.blue) begin
                        report_mismatch("blue", want.blue, m_data.blue);
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_rgb.push_back(predict_rgb(s_data));
            end
        end
    end

    // Stall the result side at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drive one word, idling first at random, and hold it until accepted
    task automatic send_pixel(hsv_pixel_t px);
        @(negedge aclk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_hsv(int hue, int sat, int val);
        hsv_pixel_t px;
        px.hue_sixtyfourths = hue[15:0];
        px.saturation       = sat[7:0];
        px.brightness       = val[7:0];
        send_pixel(px);
    endtask

    // Drop valid and hold off until every expected word has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_rgb.size() != 0) @(negedge aclk);
    endtask

    // Random word, biased toward sector edges and level extremes
    function automatic hsv_pixel_t random_pixel();
        hsv_pixel_t px;
        int         pick;
        pick = $urandom_range(9);
        if (pick < 3) begin
            px.hue_sixtyfourths = 16'($urandom_range(17) * HUE_SECTOR + $urandom_range(3));
            if ($urandom_range(1) == 1 && px.hue_sixtyfourths > 4) begin
                px.hue_sixtyfourths = px.hue_sixtyfourths - 16'd4;
            end
        end else begin
            px.hue_sixtyfourths = 16'($urandom_range(65535));
        end
        pick = $urandom_range(7);
        px.saturation = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(255));
        pick = $urandom_range(7);
        px.brightness = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(255));
        return px;
    endfunction

    // Extremes of the fields, hue wrap, gray and black
    task automatic test_corner_pixels();
        send_hsv(0, 255, 255);
        send_hsv(65535, 255, 255);
        send_hsv(23039, 255, 255);
        send_hsv(23040, 200, 180);
        send_hsv(46080, 255, 255);
        send_hsv(5000, 0, 200);
        send_hsv(9000, 255, 0);
        send_hsv(14000, 0, 0);
        send_hsv(1, 1, 1);
        send_hsv(30000, 128, 255);
    endtask

    // Each sector start and the middle of each sector
    task automatic test_sector_boundaries();
        for (int k = 0; k < 6; k++) begin
            send_hsv(k * HUE_SECTOR, 255, 255);
            send_hsv(k * HUE_SECTOR + HUE_SECTOR / 2, 170, 230);
        end
    endtask

    // Random words under the current idling profile
    task automatic test_random_pixels(int count);
        for (int i = 0; i < count; i++) begin
            send_pixel(random_pixel());
        end
    endtask

    // Sender holds off until the pipeline is empty, then resumes
    task automatic test_drain_pause();
        test_random_pixels(20);
        wait_drained();
        test_random_pixels(20);
    endtask

    initial begin
        // Hold reset, then release it at a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 29;
        rx_idle_pct = 57;
        test_corner_pixels();
        test_sector_boundaries();
        test_random_pixels(RANDOM_WORDS / 3);
        test_drain_pause();

        tx_idle_pct = 57;
        rx_idle_pct = 29;
        test_random_pixels(RANDOM_WORDS / 3);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_pixels(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3) - 40);

        // Let the pipeline empty, then watch for stray words
        wait_drained();
        repeat (4 * NUM_STAGES) @(posedge aclk);

        $display("Sent %0d HSV words (all six sectors, hue wrap, gray and black corners),",
                 words_sent);
        $display("checked %0d RGB words under three stall profiles and one drain pause.",
                 words_checked);
        if (error_count == 0 && expected_rgb.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv_to_rgb_converter.sv
sim/hsv_to_rgb_converter_test.sv
